[sv/smdrv_pkg.sv]
// Shared types, codes and drive tables for the stepper phase driver.
`default_nettype none
package smdrv_pkg;

  localparam int unsigned SineEntries = 32;
  localparam int unsigned IdxW        = $clog2(SineEntries);
  localparam int unsigned PeriodW     = 16;
  localparam int unsigned TotalW      = 32;
  localparam int unsigned TickW       = 32;

  localparam logic [1:0] OP_FORWARD = 2'd0;
  localparam logic [1:0] OP_REVERSE = 2'd1;
  localparam logic [1:0] OP_BRAKE   = 2'd2;
  localparam logic [1:0] OP_COAST   = 2'd3;

  localparam logic [1:0] MODE_FULL  = 2'd0;
  localparam logic [1:0] MODE_HALF  = 2'd1;
  localparam logic [1:0] MODE_MICRO = 2'd2;

  localparam logic CFG_STEP_MODE   = 1'b0;
  localparam logic CFG_STEP_PERIOD = 1'b1;

  localparam logic [1:0]         ModeReset   = MODE_MICRO;
  localparam logic [PeriodW-1:0] PeriodReset = 16'd1000;

  // coils: [3] a_plus, [2] a_minus, [1] b_plus, [0] b_minus
  typedef struct packed {
    logic [3:0]        coils;
    logic              stepped;
    logic [IdxW-1:0]   phase;
    logic [TotalW-1:0] total;
  } smdrv_res_t;

  function automatic logic [7:0] sine_lut(input logic [IdxW-1:0] i);
    logic [7:0] v;
    unique case (i)
      5'd0:  v = 8'd128;
      5'd1:  v = 8'd152;
      5'd2:  v = 8'd176;
      5'd3:  v = 8'd198;
      5'd4:  v = 8'd218;
      5'd5:  v = 8'd234;
      5'd6:  v = 8'd245;
      5'd7:  v = 8'd253;
      5'd8:  v = 8'd255;
      5'd9:  v = 8'd253;
      5'd10: v = 8'd245;
      5'd11: v = 8'd234;
      5'd12: v = 8'd218;
      5'd13: v = 8'd198;
      5'd14: v = 8'd176;
      5'd15: v = 8'd152;
      5'd16: v = 8'd128;
      5'd17: v = 8'd103;
      5'd18: v = 8'd79;
      5'd19: v = 8'd57;
      5'd20: v = 8'd37;
      5'd21: v = 8'd21;
      5'd22: v = 8'd10;
      5'd23: v = 8'd2;
      5'd24: v = 8'd0;
      5'd25: v = 8'd2;
      5'd26: v = 8'd10;
      5'd27: v = 8'd21;
      5'd28: v = 8'd37;
      5'd29: v = 8'd57;
      5'd30: v = 8'd79;
      default: v = 8'd103;
    endcase
    return v;
  endfunction

  function automatic logic [3:0] full_row(input logic [1:0] i);
    logic [3:0] r;
    unique case (i)
      2'd0: r = 4'b1010;
      2'd1: r = 4'b0110;
      2'd2: r = 4'b0101;
      default: r = 4'b1001;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] half_row(input logic [2:0] i);
    logic [3:0] r;
    unique case (i)
      3'd0: r = 4'b1010;
      3'd1: r = 4'b0010;
      3'd2: r = 4'b0110;
      3'd3: r = 4'b0100;
      3'd4: r = 4'b0101;
      3'd5: r = 4'b0001;
      3'd6: r = 4'b1001;
      default: r = 4'b1000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/smdrv_levels.sv]
// Coil drive levels from step mode, phase index and PWM counter.
`default_nettype none
module smdrv_levels
  import smdrv_pkg::*;
(
  input  logic [1:0]      mode_i,
  input  logic [IdxW-1:0] idx_i,
  input  logic [7:0]      pwm_i,
  output logic [3:0]      coils_o
);

  logic [7:0]      va;
  logic [7:0]      vb;
  logic [IdxW-1:0] idx_b;

  assign idx_b = idx_i + IdxW'(SineEntries / 4);
  assign va    = sine_lut(idx_i);
  assign vb    = sine_lut(idx_b);

  always_comb begin
    unique case (mode_i)
      MODE_FULL: coils_o = full_row(idx_i[1:0]);
      MODE_HALF: coils_o = half_row(idx_i[2:0]);
      default: begin
        coils_o = {pwm_i < va, pwm_i < (8'd255 - va),
                   pwm_i < vb, pwm_i < (8'd255 - vb)};
      end
    endcase
  end

endmodule
`default_nettype wire

[sv/smdrv_core.sv]
// Step timing, phase index and step total state with per-tick result logic.
`default_nettype none
module smdrv_core
  import smdrv_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  logic [1:0]         mode_i,
  input  logic [PeriodW-1:0] period_i,
  input  logic [1:0]         op_i,
  input  logic               clear_i,
  output smdrv_res_t         res_o
);

  logic [TickW-1:0]  tick_q, tick_d;
  logic [TickW-1:0]  last_q, last_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [TotalW-1:0] total_q, total_d;

  logic [TickW-1:0]  elapsed;
  logic              drive;
  logic              step;
  logic              up;
  logic [IdxW-1:0]   mask;
  logic [IdxW-1:0]   idx_next;
  logic [TotalW-1:0] total_base;
  logic [3:0]        table_lv;

  smdrv_levels u_levels (
    .mode_i  (mode_i),
    .idx_i   (idx_q),
    .pwm_i   (tick_q[7:0]),
    .coils_o (table_lv)
  );

  always_comb begin
    unique case (mode_i)
      MODE_FULL: mask = IdxW'(3);
      MODE_HALF: mask = IdxW'(7);
      default:   mask = IdxW'(SineEntries - 1);
    endcase
  end

  assign elapsed    = tick_q - last_q;
  assign drive      = (op_i == OP_FORWARD) || (op_i == OP_REVERSE);
  assign step       = drive && (elapsed >= {{(TickW-PeriodW){1'b0}}, period_i});
  assign up         = (mode_i >= MODE_MICRO) ? (op_i == OP_REVERSE) : (op_i == OP_FORWARD);
  assign idx_next   = (up ? idx_q + IdxW'(1) : idx_q - IdxW'(1)) & mask;
  assign total_base = clear_i ? '0 : total_q;

  always_comb begin
    tick_d  = tick_q + TickW'(1);
    last_d  = step ? tick_q : last_q;
    idx_d   = step ? idx_next : idx_q;
    total_d = step ? total_base + TotalW'(1) : total_base;
  end

  always_comb begin
    unique case (op_i)
      OP_BRAKE: res_o.coils = 4'b1111;
      OP_COAST: res_o.coils = 4'b0000;
      default:  res_o.coils = table_lv;
    endcase
    res_o.stepped = step;
    res_o.phase   = idx_d;
    res_o.total   = total_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      last_q  <= '0;
      idx_q   <= '0;
      total_q <= '0;
    end else if (fire_i) begin
      tick_q  <= tick_d;
      last_q  <= last_d;
      idx_q   <= idx_d;
      total_q <= total_d;
    end
  end

endmodule
`default_nettype wire

[sv/stepper_microstep_phase_driver_top.sv]
// Top level of the stepper phase driver: channels, config registers, pipeline registers.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one tick per transaction:
//   operation_i (forward, reverse, brake, coast) and clear_total_i.
//   Output channel (out_valid_o/out_ready_i) returns one result per tick:
//   four coil levels, stepped_o, phase_now_o and step_total_o.
//   Config channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) writes
//   step_mode (index 0) and step_period (index 1); always ready. Write only
//   while no tick is in flight.
// Timing: a result is valid the cycle after its tick is taken from the input
//   register; the input register holds the tick while the receiver stalls.
// Throughput: one tick per cycle while the receiver is ready; the compare and step
//   logic sits between the input register and the result register.
// Reset: tick count, last step time, phase index and step total go to zero;
//   step_mode resets to microstep, step_period to 1000.
// Stall: the result register holds while out_ready_i is low; the input
//   register takes one more tick, then in_ready_o drops.
`default_nettype none
module stepper_microstep_phase_driver_top
  import smdrv_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [PeriodW-1:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic               clear_total_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               coil_a_plus_o,
  output logic               coil_a_minus_o,
  output logic               coil_b_plus_o,
  output logic               coil_b_minus_o,
  output logic               stepped_o,
  output logic [IdxW-1:0]    phase_now_o,
  output logic [TotalW-1:0]  step_total_o
);

  logic [1:0]         mode_q;
  logic [PeriodW-1:0] period_q;
  logic               in_valid_q;
  logic [1:0]         op_q;
  logic               clr_q;
  logic               out_valid_q;
  smdrv_res_t         res;
  smdrv_res_t         res_q;
  logic               fire;

  assign cfg_ready_o = 1'b1;
  assign fire        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || fire;

  smdrv_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .mode_i   (mode_q),
    .period_i (period_q),
    .op_i     (op_q),
    .clear_i  (clr_q),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeReset;
      period_q <= PeriodReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_STEP_MODE:   mode_q   <= cfg_data_i[1:0];
        CFG_STEP_PERIOD: period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q  <= operation_i;
      clr_q <= clear_total_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign coil_a_plus_o  = res_q.coils[3];
  assign coil_a_minus_o = res_q.coils[2];
  assign coil_b_plus_o  = res_q.coils[1];
  assign coil_b_minus_o = res_q.coils[0];
  assign stepped_o      = res_q.stepped;
  assign phase_now_o    = res_q.phase;
  assign step_total_o   = res_q.total;

  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o)
    else $error("tick taken but no result presented");

  a_brake_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (op_q == OP_BRAKE) |=>
      coil_a_plus_o && coil_a_minus_o && coil_b_plus_o && coil_b_minus_o && !stepped_o)
    else $error("brake tick must drive all high without stepping");

  a_coast_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (op_q == OP_COAST) |=>
      !coil_a_plus_o && !coil_a_minus_o && !coil_b_plus_o && !coil_b_minus_o && !stepped_o)
    else $error("coast tick must drive all low without stepping");

  a_full_step_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stepped_o && (mode_q == MODE_FULL) |-> (phase_now_o[4:2] == 3'd0))
    else $error("full step index left four-row range");

endmodule
`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the stepper phase driver with its own drive and step predictor.
`default_nettype none
module tb_top
  import smdrv_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;

  localparam logic [7:0] SINE_TAB [32] = '{
    8'd128, 8'd152, 8'd176, 8'd198, 8'd218, 8'd234, 8'd245, 8'd253,
    8'd255, 8'd253, 8'd245, 8'd234, 8'd218, 8'd198, 8'd176, 8'd152,
    8'd128, 8'd103, 8'd79,  8'd57,  8'd37,  8'd21,  8'd10,  8'd2,
    8'd0,   8'd2,   8'd10,  8'd21,  8'd37,  8'd57,  8'd79,  8'd103
  };
  localparam logic [3:0] FULL_TAB [4] = '{4'b1010, 4'b0110, 4'b0101, 4'b1001};
  localparam logic [3:0] HALF_TAB [8] = '{
    4'b1010, 4'b0010, 4'b0110, 4'b0100, 4'b0101, 4'b0001, 4'b1001, 4'b1000
  };

  typedef struct packed {
    logic [1:0] op;
    logic       clr;
  } tick_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_index_i   = CFG_STEP_MODE;
  logic [PeriodW-1:0] cfg_data_i    = '0;
  logic               in_valid_i    = 1'b0;
  logic               in_ready_o;
  logic [1:0]         operation_i   = OP_COAST;
  logic               clear_total_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i   = 1'b0;
  logic               coil_a_plus_o;
  logic               coil_a_minus_o;
  logic               coil_b_plus_o;
  logic               coil_b_minus_o;
  logic               stepped_o;
  logic [IdxW-1:0]    phase_now_o;
  logic [TotalW-1:0]  step_total_o;

  stepper_microstep_phase_driver_top DUT (.*);

  // predictor state
  logic [1:0]         drv_mode   = ModeReset;
  logic [PeriodW-1:0] drv_period = PeriodReset;
  logic [TickW-1:0]   drv_tick   = '0;
  logic [TickW-1:0]   drv_last   = '0;
  logic [IdxW-1:0]    drv_phase  = '0;
  logic [TotalW-1:0]  drv_total  = '0;

  tick_t      pending_ticks[$];
  smdrv_res_t expected_drive[$];
  int         mismatches = 0;
  int         cycles     = 0;
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  logic       rx_hold    = 1'b0;
  logic       rx_hold_go = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic smdrv_res_t next_drive(input tick_t t);
    smdrv_res_t       r;
    logic [IdxW-1:0]  mask;
    logic [IdxW-1:0]  i;
    logic [7:0]       p;
    logic [7:0]       va;
    logic [7:0]       vb;
    logic [TickW-1:0] since;
    logic             up;
    r    = '0;
    mask = (drv_mode == MODE_FULL) ? 5'd3 : (drv_mode == MODE_HALF) ? 5'd7 : 5'd31;
    i    = drv_phase & mask;
    if (t.clr) drv_total = '0;
    if (t.op == OP_BRAKE) begin
      r.coils = 4'b1111;
    end else if (t.op == OP_COAST) begin
      r.coils = 4'b0000;
    end else begin
      if (drv_mode == MODE_FULL) begin
        r.coils = FULL_TAB[i[1:0]];
      end else if (drv_mode == MODE_HALF) begin
        r.coils = HALF_TAB[i[2:0]];
      end else begin
        p  = drv_tick[7:0];
        va = SINE_TAB[i];
        vb = SINE_TAB[(i + 5'd8) & mask];
        r.coils = {p < va, p < (8'd255 - va), p < vb, p < (8'd255 - vb)};
      end
      since = drv_tick - drv_last;
      if (since >= {16'd0, drv_period}) begin
        up = (drv_mode >= MODE_MICRO) ? (t.op == OP_REVERSE) : (t.op == OP_FORWARD);
        drv_phase = (up ? drv_phase + 5'd1 : drv_phase - 5'd1) & mask;
        drv_last  = drv_tick;
        drv_total = drv_total + 1;
        r.stepped = 1'b1;
      end
    end
    drv_tick = drv_tick + 1;
    r.phase  = drv_phase;
    r.total  = drv_total;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o)
        expected_drive.push_back(next_drive('{op: operation_i, clr: clear_total_i}));
      if (in_valid_i && !in_ready_o) begin
        in_valid_i <= 1'b1;
      end else if (pending_ticks.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_valid_i    <= 1'b1;
        operation_i   <= pending_ticks[0].op;
        clear_total_i <= pending_ticks[0].clr;
        void'(pending_ticks.pop_front());
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    smdrv_res_t got;
    smdrv_res_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got = '{coils: {coil_a_plus_o, coil_a_minus_o, coil_b_plus_o, coil_b_minus_o},
                stepped: stepped_o, phase: phase_now_o, total: step_total_o};
        if (expected_drive.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transaction: coils %b stepped %b phase %0d total %0d",
                     got.coils, got.stepped, got.phase, got.total);
        end else begin
          want = expected_drive.pop_front();
          if (got.coils !== want.coils || got.stepped !== want.stepped ||
              got.phase !== want.phase || got.total !== want.total) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp coils %b stepped %b phase %0d total %0d, %s%0d %s%0d",
                       want.coils, want.stepped, want.phase, want.total,
                       $sformatf("got coils %b stepped %b phase ", got.coils, got.stepped),
                       got.phase, "total ", got.total);
          end
        end
      end
      out_ready_i <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    wait (rx_hold_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [PeriodW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_STEP_MODE) drv_mode = data[1:0];
    else drv_period = data;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_drive(input logic [1:0] mode, input logic [PeriodW-1:0] period);
    write_reg(CFG_STEP_MODE, {14'($urandom_range(0, 16383)), mode});
    write_reg(CFG_STEP_PERIOD, period);
    @(negedge clk_i);
  endtask

  task automatic push_tick(input logic [1:0] op, input logic clr);
    pending_ticks.push_back('{op: op, clr: clr});
  endtask

  task automatic push_random_ticks(input int n);
    int r;
    repeat (n) begin
      r = $urandom_range(9);
      push_tick(r < 4 ? OP_FORWARD : r < 8 ? OP_REVERSE : r == 8 ? OP_BRAKE : OP_COAST,
                $urandom_range(9) == 0);
    end
  endtask

  task automatic drain();
    while (pending_ticks.size() != 0 || in_valid_i || expected_drive.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [PeriodW-1:0] pick_period();
    int sel;
    sel = $urandom_range(9);
    if (sel < 4) return PeriodW'($urandom_range(0, 3));
    if (sel < 7) return PeriodW'($urandom_range(4, 20));
    if (sel == 7) return PeriodW'($urandom_range(21, 300));
    if (sel == 8) return 16'hFFFF;
    return PeriodW'($urandom_range(0, 65535));
  endfunction

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // reset settings, then full, half, unused mode code and back to full
    tx_idle_pct <= 10;
    rx_idle_pct <= 30;
    push_tick(OP_FORWARD, 1'b0);
    push_tick(OP_REVERSE, 1'b1);
    drain();
    set_drive(MODE_FULL, 16'd0);
    repeat (4) push_tick(OP_FORWARD, 1'b0);
    repeat (2) push_tick(OP_REVERSE, 1'b0);
    push_tick(OP_BRAKE, 1'b1);
    push_tick(OP_COAST, 1'b0);
    push_tick(OP_FORWARD, 1'b1);
    drain();
    set_drive(MODE_HALF, 16'd1);
    repeat (3) push_tick(OP_FORWARD, 1'b0);
    repeat (2) push_tick(OP_REVERSE, 1'b0);
    drain();
    set_drive(2'd3, 16'd0);
    repeat (3) push_tick(OP_FORWARD, 1'b0);
    push_tick(OP_REVERSE, 1'b0);
    push_tick(OP_BRAKE, 1'b0);
    push_tick(OP_COAST, 1'b1);
    drain();
    set_drive(MODE_FULL, 16'hFFFF);
    push_tick(OP_FORWARD, 1'b0);
    drain();

    for (int stage = 0; stage < 3; stage++) begin
      tx_idle_pct <= (stage == 0) ? 10 : (stage == 1) ? 59 : 0;
      rx_idle_pct <= (stage == 0) ? 59 : (stage == 1) ? 10 : 0;
      for (int batch = 0; batch < 4; batch++) begin
        set_drive(2'($urandom_range(3)), pick_period());
        if (stage == 2 && batch == 0) rx_hold_go <= 1'b1;
        push_random_ticks(33);
        drain();
      end
    end

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
